FILE: rtl/mnsp_pkg.sv
// Package: shared types, codes and lookup tables for the melody note string parser.
package mnsp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned PeriodW = 12;
  localparam int unsigned CmpW    = 11;
  localparam int unsigned DurW    = 16;
  localparam int unsigned AccW    = 10;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned OctW    = 4;

  localparam logic [DurW-1:0]  REST_MS_RESET = 16'd100;
  localparam logic [CharW-1:0] CHAR_NUL      = 8'h00;
  localparam logic [CharW-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [CharW-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE     = 8'h39;

  typedef enum logic [1:0] {
    KIND_TONE  = 2'd0,
    KIND_REST  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_LETTER = 3'd0,
    PH_OCTAVE = 3'd1,
    PH_DIG0   = 3'd2,
    PH_DIG1   = 3'd3,
    PH_DIG2   = 3'd4
  } phase_e;

  typedef struct packed {
    logic               valid;
    kind_e              kind;
    logic [PeriodW-1:0] tone_period;
    logic [CmpW-1:0]    compare_value;
    logic [DurW-1:0]    duration_ms;
  } result_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
  } note_hit_t;

  // Chromatic letter table: C c D d E F f G g A a B
  function automatic note_hit_t note_lookup(input logic [CharW-1:0] c);
    note_hit_t h;
    h.found = 1'b1;
    case (c)
      "C":     h.idx = 4'd0;
      "c":     h.idx = 4'd1;
      "D":     h.idx = 4'd2;
      "d":     h.idx = 4'd3;
      "E":     h.idx = 4'd4;
      "F":     h.idx = 4'd5;
      "f":     h.idx = 4'd6;
      "G":     h.idx = 4'd7;
      "g":     h.idx = 4'd8;
      "A":     h.idx = 4'd9;
      "a":     h.idx = 4'd10;
      "B":     h.idx = 4'd11;
      default: begin
        h.found = 1'b0;
        h.idx   = 4'd0;
      end
    endcase
    return h;
  endfunction

  function automatic logic [PeriodW-1:0] base_period(input logic [IdxW-1:0] idx);
    logic [PeriodW-1:0] p;
    case (idx)
      4'd0:    p = 12'd3058;
      4'd1:    p = 12'd2886;
      4'd2:    p = 12'd2724;
      4'd3:    p = 12'd2571;
      4'd4:    p = 12'd2427;
      4'd5:    p = 12'd2291;
      4'd6:    p = 12'd2162;
      4'd7:    p = 12'd2041;
      4'd8:    p = 12'd1926;
      4'd9:    p = 12'd1818;
      4'd10:   p = 12'd1716;
      4'd11:   p = 12'd1620;
      default: p = 12'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/melody_note_string_parser.sv
// Top level: melody note string parser with input register, parser core and result register.
//
//   channel   direction  handshake                payload
//   in        request    in_valid_i / in_ready_o  char_code_i
//   out       result     out_valid_o / out_ready_i kind_o, tone_period_o,
//                                                  compare_value_o, duration_ms_o
//   rest_ms   config     rest_ms_we_i             rest_ms_i
//
// One character per cycle sustained while the result is not stalled: a request
// is registered in the input register, then the parser core updates its token
// state and the result register loads in the same edge.
// Only the last character of a note token or a space between tokens gives a
// result; other characters leave nothing in the result register.
// Reset clears the token state, both valid flags, and loads rest_ms with 100.
// A stalled result holds the core; the input register keeps one more request.
module melody_note_string_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mnsp_pkg::CharW-1:0]   char_code_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   kind_o,
  output logic [mnsp_pkg::PeriodW-1:0] tone_period_o,
  output logic [mnsp_pkg::CmpW-1:0]    compare_value_o,
  output logic [mnsp_pkg::DurW-1:0]    duration_ms_o,
  input  logic                         rest_ms_we_i,
  input  logic [mnsp_pkg::DurW-1:0]    rest_ms_i
);
  import mnsp_pkg::*;

  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             out_valid_q;
  result_t          res_q;
  result_t          core_res;
  logic [DurW-1:0]  rest_ms_q;
  logic             advance;

  // Advance the held request into the core whenever the result slot is free
  // or being drained this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_ms_q <= REST_MS_RESET;
    end else if (rest_ms_we_i) begin
      rest_ms_q <= rest_ms_i;
    end
  end

  // Input register: take a new request when the slot empties or advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_char_q <= char_code_i;
    end
  end

  mnsp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .char_i    (in_char_q),
    .rest_ms_i (rest_ms_q),
    .result_o  (core_res)
  );

  // Result register: drop on handshake, load when the core emits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= core_res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_res.valid) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = res_q.kind;
  assign tone_period_o   = res_q.tone_period;
  assign compare_value_o = res_q.compare_value;
  assign duration_ms_o   = res_q.duration_ms;

endmodule

FILE: rtl/mnsp_core.sv
// Parser core: token state registers, next-state logic and result formation.
module mnsp_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [mnsp_pkg::CharW-1:0]  char_i,
  input  logic [mnsp_pkg::DurW-1:0]   rest_ms_i,
  output mnsp_pkg::result_t           result_o
);
  import mnsp_pkg::*;

  phase_e          phase_q, phase_d;
  logic [IdxW-1:0] note_q, note_d;
  logic [OctW-1:0] oct_q, oct_d;
  logic [AccW-1:0] dur_q, dur_d;
  logic            err_q, err_d;

  logic            is_nul, is_space, is_digit;
  logic [3:0]      digit;
  logic [AccW-1:0] dur_mac;
  note_hit_t       hit;
  logic [PeriodW-1:0] period;

  always_comb begin
    is_nul   = (char_i == CHAR_NUL);
    is_space = (char_i == CHAR_SPACE);
    is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
    digit    = char_i[3:0];
    dur_mac  = AccW'((14'(dur_q) * 14'd10) + 14'(digit));
    hit      = note_lookup(char_i);
    period   = base_period(note_q) >> oct_q;
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      if (is_nul) begin
        phase_d = PH_LETTER;
      end else begin
        case (phase_q)
          PH_LETTER: phase_d = is_space ? PH_LETTER : PH_OCTAVE;
          PH_OCTAVE: phase_d = PH_DIG0;
          PH_DIG0:   phase_d = PH_DIG1;
          PH_DIG1:   phase_d = PH_DIG2;
          PH_DIG2:   phase_d = PH_LETTER;
          default:   phase_d = PH_LETTER;
        endcase
      end
    end
  end

  // Token fields and result
  always_comb begin
    note_d   = note_q;
    oct_d    = oct_q;
    dur_d    = dur_q;
    err_d    = err_q;
    result_o = '0;
    if (step_i) begin
      if (is_nul) begin
        note_d = '0;
        oct_d  = '0;
        dur_d  = '0;
        err_d  = 1'b0;
      end else begin
        case (phase_q)
          PH_LETTER: begin
            if (is_space) begin
              result_o.valid       = 1'b1;
              result_o.kind        = KIND_REST;
              result_o.duration_ms = rest_ms_i;
            end else begin
              note_d = hit.idx;
              err_d  = !hit.found;
              oct_d  = '0;
              dur_d  = '0;
            end
          end
          PH_OCTAVE: begin
            if (is_digit) oct_d = digit;
            else          err_d = 1'b1;
          end
          PH_DIG0, PH_DIG1: begin
            if (is_digit) dur_d = dur_mac;
            else          err_d = 1'b1;
          end
          PH_DIG2: begin
            result_o.valid = 1'b1;
            if (err_q || !is_digit) begin
              result_o.kind = KIND_ERROR;
            end else begin
              result_o.kind          = KIND_TONE;
              result_o.tone_period   = period;
              result_o.compare_value = period[PeriodW-1:1];
              result_o.duration_ms   = DurW'(dur_mac);
            end
            note_d = '0;
            oct_d  = '0;
            dur_d  = '0;
            err_d  = 1'b0;
          end
          default: begin
            err_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LETTER;
      note_q  <= '0;
      oct_q   <= '0;
      dur_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      note_q  <= note_d;
      oct_q   <= oct_d;
      dur_q   <= dur_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: rtl/mnsp_checker.sv
// Checker: port-level assertions for the melody note string parser, with bind.
module mnsp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   kind_o,
  input logic [mnsp_pkg::PeriodW-1:0] tone_period_o,
  input logic [mnsp_pkg::CmpW-1:0]    compare_value_o,
  input logic [mnsp_pkg::DurW-1:0]    duration_ms_o
);
  import mnsp_pkg::*;

  // Hold a stalled result with its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(tone_period_o) && $stable(compare_value_o) && $stable(duration_ms_o))
    else $error("stalled result changed");

  a_tone_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_TONE) |->
      (compare_value_o == tone_period_o[PeriodW-1:1]) && (tone_period_o != '0))
    else $error("tone compare value is not half the period");

  a_no_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((kind_o == KIND_REST) || (kind_o == KIND_ERROR)) |->
      (tone_period_o == '0) && (compare_value_o == '0))
    else $error("rest or error result carries a period");

  a_err_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ERROR) |-> duration_ms_o == '0)
    else $error("error result carries a duration");

endmodule

bind melody_note_string_parser mnsp_checker u_mnsp_checker (.*);
